[rtl/price_ladder_lookup_unit_macros.svh]
// Assertion macros shared by the price ladder lookup checks.
`ifndef PRICE_LADDER_LOOKUP_UNIT_MACROS_SVH
`define PRICE_LADDER_LOOKUP_UNIT_MACROS_SVH

// Checked only outside reset.
`define PLU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("price ladder lookup check failed");

// Checked on every edge, reset included.
`define PLU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("price ladder lookup check failed");

`endif

[rtl/plu_pkg.sv]
// Shared widths, codes and types of the price ladder lookup unit.
`default_nettype none
package plu_pkg;

  localparam int OP_W        = 2;
  localparam int IDX_IN_W    = 12;
  localparam int PRICE_IO_W  = 32;
  localparam int IDX_OUT_W   = 10;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 11;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_TO_INDEX = 2'd1,
    OP_TO_PRICE = 2'd2,
    OP_TICK     = 2'd3
  } opcode_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

  // Work handed from the front end to the sequencer.
  typedef enum logic [2:0] {
    K_DONE,
    K_WRITE,
    K_READ,
    K_STEP,
    K_SEARCH
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 strict;
    logic [STATUS_W-1:0]  status;
  } cmd_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_STEP1,
    B_STEP2,
    B_CHK0,
    B_CHKHI,
    B_CHKMID
  } bstate_t;

endpackage
`default_nettype wire

[rtl/plu_if.sv]
// Request and response channel interfaces of the price ladder lookup unit.
`default_nettype none
interface plu_in_if;
  logic                                valid;
  logic                                ready;
  logic [plu_pkg::OP_W-1:0]            opcode;
  logic signed [plu_pkg::IDX_IN_W-1:0] index_in;
  logic [plu_pkg::PRICE_IO_W-1:0]      price_in;
  logic                                strict;

  modport source (output valid, opcode, index_in, price_in, strict, input ready);
  modport sink   (input valid, opcode, index_in, price_in, strict, output ready);
endinterface

interface plu_out_if;
  logic                            valid;
  logic                            ready;
  logic [plu_pkg::IDX_OUT_W-1:0]   index_out;
  logic [plu_pkg::PRICE_IO_W-1:0]  price_out;
  logic [plu_pkg::STATUS_W-1:0]    status;

  modport source (output valid, index_out, price_out, status, input ready);
  modport sink   (input valid, index_out, price_out, status, output ready);
endinterface
`default_nettype wire

[rtl/price_ladder_lookup_unit.sv]
// Price ladder lookup unit: front end, command queue and ladder sequencer.
// Requests pass through the command queue to the sequencer, which registers each result.
// Writes and immediate answers are given from idle; index-to-price and tick step read the
// ladder memory, and price-to-index bisects it (one bisection step per ladder memory read, one read a cycle).
// The sequencer takes a new item only once it is idle and its result register is free.
// Reset clears entry count, queue, sequencer and result valid; ladder is not cleared.
`default_nettype none
module price_ladder_lookup_unit #(
  parameter int LADDER_DEPTH = 1024,
  parameter int PRICE_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [plu_pkg::CNT_W-1:0] cfg_wdata,
  plu_in_if.sink                    req,
  plu_out_if.source                 rsp
);

  localparam int IW = $clog2(LADDER_DEPTH);
  localparam int QW = $bits(plu_pkg::cmd_ctl_t) + IW + PRICE_BITS;

  plu_pkg::cmd_ctl_t     f_ctl;
  logic [IW-1:0]         f_addr;
  logic [PRICE_BITS-1:0] f_price;
  logic                  f_valid;
  logic                  f_ready;

  plu_pkg::cmd_ctl_t     b_ctl;
  logic [IW-1:0]         b_addr;
  logic [PRICE_BITS-1:0] b_price;
  logic                  b_valid;
  logic                  b_ready;

  logic [QW-1:0]         push_data;
  logic [QW-1:0]         pop_data;

  plu_front #(
    .LADDER_DEPTH(LADDER_DEPTH),
    .PRICE_BITS  (PRICE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd_ctl  (f_ctl),
    .cmd_addr (f_addr),
    .cmd_price(f_price)
  );

  assign push_data = {f_ctl, f_addr, f_price};

  plu_queue #(
    .DW(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (push_data),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (pop_data)
  );

  assign {b_ctl, b_addr, b_price} = pop_data;

  plu_back #(
    .LADDER_DEPTH(LADDER_DEPTH),
    .PRICE_BITS  (PRICE_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(b_valid),
    .q_ready(b_ready),
    .q_ctl  (b_ctl),
    .q_addr (b_addr),
    .q_price(b_price),
    .rsp    (rsp)
  );

endmodule
`default_nettype wire

[rtl/plu_front.sv]
// Front end: entry count register, request decode and address clamping.
`default_nettype none
module plu_front #(
  parameter int LADDER_DEPTH = 1024,
  parameter int PRICE_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [plu_pkg::CNT_W-1:0]          cfg_wdata,
  plu_in_if.sink                             req,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output plu_pkg::cmd_ctl_t                  cmd_ctl,
  output logic [$clog2(LADDER_DEPTH)-1:0]    cmd_addr,
  output logic [PRICE_BITS-1:0]              cmd_price
);

  localparam int IW = $clog2(LADDER_DEPTH);
  localparam int NW = $clog2(LADDER_DEPTH + 1);
  localparam int MW = (NW > plu_pkg::CNT_W) ? NW : plu_pkg::CNT_W;
  localparam int SW = ((MW > plu_pkg::IDX_IN_W) ? MW : plu_pkg::IDX_IN_W) + 1;

  logic [plu_pkg::CNT_W-1:0]              entry_count;
  logic [MW-1:0]                          ec_w;
  logic [MW-1:0]                          depth_w;
  logic [MW-1:0]                          n_w;
  logic signed [SW-1:0]                   idx_s;
  logic signed [SW-1:0]                   n_s;
  logic signed [SW-1:0]                   nm1_s;
  logic signed [SW-1:0]                   nm2_s;
  logic signed [SW-1:0]                   depth_s;
  logic                                   idx_neg;
  logic [PRICE_BITS+plu_pkg::PRICE_IO_W-1:0] px_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  assign ec_w    = MW'(entry_count);
  assign depth_w = MW'(LADDER_DEPTH);
  assign n_w     = (ec_w < depth_w) ? ec_w : depth_w;
  assign idx_s   = SW'(req.index_in);
  assign idx_neg = idx_s[SW-1];
  assign n_s     = SW'(n_w);
  assign nm1_s   = n_s - SW'(1);
  assign nm2_s   = n_s - SW'(2);
  assign depth_s = SW'(LADDER_DEPTH);
  assign px_ext  = {{PRICE_BITS{1'b0}}, req.price_in};

  assign cmd_valid = req.valid;
  assign req.ready = cmd_ready;

  always_comb begin
    cmd_ctl.kind   = plu_pkg::K_DONE;
    cmd_ctl.strict = req.strict;
    cmd_ctl.status = plu_pkg::ST_OK;
    cmd_addr       = '0;
    cmd_price      = px_ext[PRICE_BITS-1:0];
    unique case (plu_pkg::opcode_t'(req.opcode))
      plu_pkg::OP_WRITE: begin
        if (!idx_neg && idx_s < depth_s) begin
          cmd_ctl.kind = plu_pkg::K_WRITE;
          cmd_addr     = idx_s[IW-1:0];
        end else if (req.strict) begin
          cmd_ctl.status = plu_pkg::ST_MISS;
        end
      end
      plu_pkg::OP_TO_INDEX: begin
        if (n_w == '0) begin
          cmd_ctl.status = plu_pkg::ST_SHORT;
        end else begin
          cmd_ctl.kind = plu_pkg::K_SEARCH;
          cmd_addr     = nm1_s[IW-1:0];
        end
      end
      plu_pkg::OP_TO_PRICE: begin
        if (n_w == '0) begin
          cmd_ctl.status = plu_pkg::ST_SHORT;
        end else if (req.strict) begin
          if (!idx_neg && idx_s < n_s) begin
            cmd_ctl.kind = plu_pkg::K_READ;
            cmd_addr     = idx_s[IW-1:0];
          end else begin
            cmd_ctl.status = plu_pkg::ST_MISS;
          end
        end else begin
          cmd_ctl.kind = plu_pkg::K_READ;
          if (idx_s >= nm1_s) begin
            cmd_addr = nm1_s[IW-1:0];
          end else if (idx_neg) begin
            cmd_addr = '0;
          end else begin
            cmd_addr = idx_s[IW-1:0];
          end
        end
      end
      plu_pkg::OP_TICK: begin
        if (n_w < MW'(2)) begin
          cmd_ctl.status = plu_pkg::ST_SHORT;
        end else begin
          cmd_ctl.kind = plu_pkg::K_STEP;
          if (idx_s >= nm1_s) begin
            cmd_addr = nm2_s[IW-1:0];
          end else if (idx_neg || idx_s == '0) begin
            cmd_addr = '0;
          end else begin
            cmd_addr = idx_s[IW-1:0];
          end
        end
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/plu_queue.sv]
// Small FIFO between the front end and the sequencer.
`default_nettype none
module plu_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  localparam int PTR_W = (plu_pkg::QUEUE_DEPTH > 1) ? $clog2(plu_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(plu_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(plu_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(plu_pkg::QUEUE_DEPTH);

  logic [DW-1:0]     buf_q [plu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_QW-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_QW'(1);
      end else if (pop && !push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/plu_back.sv]
// Sequencer: ladder memory, bisection, reads, tick step and result register.
`default_nettype none
module plu_back #(
  parameter int LADDER_DEPTH = 1024,
  parameter int PRICE_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  plu_pkg::cmd_ctl_t               q_ctl,
  input  logic [$clog2(LADDER_DEPTH)-1:0] q_addr,
  input  logic [PRICE_BITS-1:0]           q_price,
  plu_out_if.source                       rsp
);

  localparam int IW  = $clog2(LADDER_DEPTH);
  localparam int OW  = plu_pkg::IDX_OUT_W;
  localparam int PIW = plu_pkg::PRICE_IO_W;

  plu_pkg::bstate_t state, state_next;

  logic [PRICE_BITS-1:0] ladder [LADDER_DEPTH];
  logic [PRICE_BITS-1:0] rdata;
  logic [IW-1:0]         rd_addr;
  logic                  mem_we;

  logic [IW-1:0]         addr, addr_next;
  logic [IW-1:0]         lo, lo_next;
  logic [IW-1:0]         hi, hi_next;
  logic [IW-1:0]         mid, mid_next;
  logic [PRICE_BITS-1:0] px, px_next;
  logic                  strict, strict_next;
  logic [PRICE_BITS-1:0] a_val, a_val_next;

  logic                          res_valid, res_valid_next;
  logic [OW-1:0]                 res_index, res_index_next;
  logic [PIW-1:0]                res_price, res_price_next;
  logic [plu_pkg::STATUS_W-1:0]  res_status, res_status_next;

  logic                  free;
  logic                  below;
  logic [IW-1:0]         nlo, nhi, nmid;
  logic [IW+OW-1:0]      hi_ext, mid_ext, nhi_ext;
  logic [PRICE_BITS+PIW-1:0] rd_ext, diff_ext;

  assign free = !res_valid || rsp.ready;

  // One bisection step on the entry read last cycle.
  assign below = px < rdata;
  assign nlo   = below ? mid : lo;
  assign nhi   = below ? hi : mid;
  assign nmid  = nlo + ((nhi - nlo) >> 1);

  assign hi_ext   = {{OW{1'b0}}, hi};
  assign mid_ext  = {{OW{1'b0}}, mid};
  assign nhi_ext  = {{OW{1'b0}}, nhi};
  assign rd_ext   = {{PIW{1'b0}}, rdata};
  assign diff_ext = {{PIW{1'b0}}, a_val - rdata};

  assign rsp.valid     = res_valid;
  assign rsp.index_out = res_index;
  assign rsp.price_out = res_price;
  assign rsp.status    = res_status;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ladder[q_addr] <= q_price;
    end
    rdata <= ladder[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plu_pkg::B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    addr       <= addr_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    px         <= px_next;
    strict     <= strict_next;
    a_val      <= a_val_next;
    res_index  <= res_index_next;
    res_price  <= res_price_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    addr_next       = addr;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    px_next         = px;
    strict_next     = strict;
    a_val_next      = a_val;
    res_valid_next  = res_valid && !rsp.ready;
    res_index_next  = res_index;
    res_price_next  = res_price;
    res_status_next = res_status;
    rd_addr         = '0;
    mem_we          = 1'b0;
    q_ready         = 1'b0;
    unique case (state)
      plu_pkg::B_IDLE: begin
        if (q_valid && free) begin
          q_ready     = 1'b1;
          addr_next   = q_addr;
          hi_next     = q_addr;
          lo_next     = '0;
          px_next     = q_price;
          strict_next = q_ctl.strict;
          unique case (q_ctl.kind)
            plu_pkg::K_WRITE: begin
              mem_we          = 1'b1;
              res_valid_next  = 1'b1;
              res_index_next  = '0;
              res_price_next  = '0;
              res_status_next = plu_pkg::ST_OK;
            end
            plu_pkg::K_READ: begin
              rd_addr    = q_addr;
              state_next = plu_pkg::B_READ;
            end
            plu_pkg::K_STEP: begin
              rd_addr    = q_addr;
              state_next = plu_pkg::B_STEP1;
            end
            plu_pkg::K_SEARCH: begin
              rd_addr    = '0;
              state_next = plu_pkg::B_CHK0;
            end
            default: begin
              res_valid_next  = 1'b1;
              res_index_next  = '0;
              res_price_next  = '0;
              res_status_next = q_ctl.status;
            end
          endcase
        end
      end
      plu_pkg::B_READ: begin
        res_valid_next  = 1'b1;
        res_index_next  = '0;
        res_price_next  = rd_ext[PIW-1:0];
        res_status_next = plu_pkg::ST_OK;
        state_next      = plu_pkg::B_IDLE;
      end
      plu_pkg::B_STEP1: begin
        a_val_next = rdata;
        rd_addr    = addr + IW'(1);
        state_next = plu_pkg::B_STEP2;
      end
      plu_pkg::B_STEP2: begin
        res_valid_next  = 1'b1;
        res_index_next  = '0;
        res_price_next  = diff_ext[PIW-1:0];
        res_status_next = plu_pkg::ST_OK;
        state_next      = plu_pkg::B_IDLE;
      end
      plu_pkg::B_CHK0: begin
        if (px >= rdata) begin
          res_valid_next  = 1'b1;
          res_price_next  = '0;
          res_index_next  = '0;
          res_status_next = (strict && px != rdata) ? plu_pkg::ST_MISS : plu_pkg::ST_OK;
          state_next      = plu_pkg::B_IDLE;
        end else begin
          rd_addr    = hi;
          state_next = plu_pkg::B_CHKHI;
        end
      end
      plu_pkg::B_CHKHI: begin
        if (px <= rdata) begin
          res_valid_next = 1'b1;
          res_price_next = '0;
          if (strict && px != rdata) begin
            res_index_next  = '0;
            res_status_next = plu_pkg::ST_MISS;
          end else begin
            res_index_next  = hi_ext[OW-1:0];
            res_status_next = plu_pkg::ST_OK;
          end
          state_next = plu_pkg::B_IDLE;
        end else begin
          mid_next   = hi >> 1;
          rd_addr    = hi >> 1;
          state_next = plu_pkg::B_CHKMID;
        end
      end
      plu_pkg::B_CHKMID: begin
        if (px == rdata) begin
          res_valid_next  = 1'b1;
          res_price_next  = '0;
          res_index_next  = mid_ext[OW-1:0];
          res_status_next = plu_pkg::ST_OK;
          state_next      = plu_pkg::B_IDLE;
        end else if (nmid == nlo || nmid == nhi) begin
          // Interval closed: never an exact hit; the answer is the lower tick, or a miss if strict.
          res_valid_next = 1'b1;
          res_price_next = '0;
          if (strict) begin
            res_index_next  = '0;
            res_status_next = plu_pkg::ST_MISS;
          end else begin
            res_index_next  = nhi_ext[OW-1:0];
            res_status_next = plu_pkg::ST_OK;
          end
          state_next = plu_pkg::B_IDLE;
        end else begin
          lo_next  = nlo;
          hi_next  = nhi;
          mid_next = nmid;
          rd_addr  = nmid;
        end
      end
      default: begin
        state_next = plu_pkg::B_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/plu_chk.sv]
// Port-level checks of the price ladder lookup unit and their bind.
`default_nettype none
`include "price_ladder_lookup_unit_macros.svh"
module plu_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [plu_pkg::IDX_OUT_W-1:0]      rsp_index,
  input logic [plu_pkg::PRICE_IO_W-1:0]     rsp_price,
  input logic [plu_pkg::STATUS_W-1:0]      rsp_status
);

  `PLU_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !rsp_valid)
  `PLU_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)
  `PLU_ASSERT(a_rsp_stable, clk, rst, (rsp_valid && !rsp_ready) |=> ($stable(rsp_index) && $stable(rsp_price) && $stable(rsp_status)))
  `PLU_ASSERT(a_error_zero, clk, rst, (rsp_valid && rsp_status != plu_pkg::ST_OK) |-> (rsp_index == '0 && rsp_price == '0))

endmodule

bind price_ladder_lookup_unit plu_chk u_plu_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_index (rsp.index_out),
  .rsp_price (rsp.price_out),
  .rsp_status(rsp.status)
);
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for price_ladder_lookup_unit: queued stimulus, ladder predictor, checks.
module testbench;

  localparam int LADDER_DEPTH = 1024;
  localparam int PRICE_BITS   = 32;

  typedef struct {
    plu_pkg::opcode_t                     op;
    logic signed [plu_pkg::IDX_IN_W-1:0]  index;
    logic [plu_pkg::PRICE_IO_W-1:0]       price;
    logic                                 strict;
  } ladder_req_t;

  typedef struct {
    logic [plu_pkg::IDX_OUT_W-1:0]  index_out;
    logic [plu_pkg::PRICE_IO_W-1:0] price_out;
    logic [plu_pkg::STATUS_W-1:0]   status;
  } ladder_answer_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [plu_pkg::CNT_W-1:0] cfg_wdata;

  plu_in_if  req_if ();
  plu_out_if rsp_if ();

  price_ladder_lookup_unit #(
    .LADDER_DEPTH(LADDER_DEPTH),
    .PRICE_BITS  (PRICE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  ladder_req_t    pending_q [$];
  ladder_answer_t answer_q [$];

  // predictor state, updated on accepted transfers and entry count writes
  bit [plu_pkg::PRICE_IO_W-1:0] ladder_img [LADDER_DEPTH];
  int                           entry_cfg;
  // stimulus-side image of the ladder, updated when items are queued
  bit [plu_pkg::PRICE_IO_W-1:0] plan_ladder [LADDER_DEPTH];
  int                           written_prefix;

  int sent_cnt;
  int accepted_cnt;
  int queued_cnt;
  int mismatch_cnt;
  int cycle_cnt;
  logic calm;

  assign calm = (cycle_cnt % 3000) < 800;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL price_ladder_lookup_unit");
    $finish;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic bit [plu_pkg::PRICE_IO_W-1:0] lad_rd(int i);
    if (i < 0 || i >= LADDER_DEPTH) return '0;
    return ladder_img[i];
  endfunction

  function automatic ladder_answer_t predict_answer(ladder_req_t it);
    ladder_answer_t               a;
    int                           idx;
    int                           n;
    int                           k;
    int                           lo;
    int                           hi;
    int                           mid;
    bit                           done;
    bit [plu_pkg::PRICE_IO_W-1:0] v;
    bit [plu_pkg::PRICE_IO_W-1:0] px;
    a.index_out = '0;
    a.price_out = '0;
    a.status    = plu_pkg::ST_OK;
    idx = it.index;
    px  = it.price;
    n   = (entry_cfg > LADDER_DEPTH) ? LADDER_DEPTH : entry_cfg;
    k   = 0;
    case (it.op)
      plu_pkg::OP_WRITE: begin
        if (idx >= 0 && idx < LADDER_DEPTH) ladder_img[idx] = px;
        else if (it.strict) a.status = plu_pkg::ST_MISS;
      end
      plu_pkg::OP_TO_INDEX: begin
        if (n < 1) begin
          a.status = plu_pkg::ST_SHORT;
        end else begin
          if (px >= lad_rd(0)) begin
            k = 0;
          end else if (px <= lad_rd(n - 1)) begin
            k = n - 1;
          end else begin
            lo   = 0;
            hi   = n - 1;
            mid  = (hi - lo) >>> 1;
            done = 1'b0;
            while (!done) begin
              v = lad_rd(mid);
              if (px < v) lo = mid;
              else if (px > v) hi = mid;
              else begin
                k    = mid;
                done = 1'b1;
              end
              if (!done) begin
                mid = lo + ((hi - lo) >>> 1);
                if (mid == lo || mid == hi) begin
                  k    = hi;
                  done = 1'b1;
                end
              end
            end
          end
          if (it.strict && lad_rd(k) != px) a.status = plu_pkg::ST_MISS;
          else a.index_out = k[plu_pkg::IDX_OUT_W-1:0];
        end
      end
      plu_pkg::OP_TO_PRICE: begin
        if (n < 1) a.status = plu_pkg::ST_SHORT;
        else if (it.strict) begin
          if (idx >= 0 && idx < n) a.price_out = lad_rd(idx);
          else a.status = plu_pkg::ST_MISS;
        end else if (idx >= n - 1) a.price_out = lad_rd(n - 1);
        else if (idx < 0) a.price_out = lad_rd(0);
        else a.price_out = lad_rd(idx);
      end
      default: begin
        if (n < 2) begin
          a.status = plu_pkg::ST_SHORT;
        end else begin
          if (idx >= n - 1) k = n - 2;
          else if (idx <= 0) k = 0;
          else k = idx;
          a.price_out = lad_rd(k) - lad_rd(k + 1);
        end
      end
    endcase
    return a;
  endfunction

  // request driver
  always @(negedge clk) begin : req_driver
    ladder_req_t it;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || accepted_cnt == sent_cnt) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        it = pending_q.pop_front();
        req_if.opcode   <= it.op;
        req_if.index_in <= it.index;
        req_if.price_in <= it.price;
        req_if.strict   <= it.strict;
        req_if.valid    <= 1'b1;
        sent_cnt = sent_cnt + 1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= rst ? 1'b0 : (calm || $urandom_range(0, 99) >= 10);
  end

  // request monitor: predict on each accepted transfer
  always @(posedge clk) begin : req_monitor
    ladder_req_t it;
    if (!rst && req_if.valid && req_if.ready) begin
      it.op     = plu_pkg::opcode_t'(req_if.opcode);
      it.index  = req_if.index_in;
      it.price  = req_if.price_in;
      it.strict = req_if.strict;
      answer_q.insert(answer_q.size(), predict_answer(it));
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : rsp_monitor
    ladder_answer_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (answer_q.size() == 0) begin
        flag_mismatch("result transfer with nothing pending");
      end else begin
        want = answer_q.pop_front();
        if (rsp_if.index_out !== want.index_out)
          flag_mismatch($sformatf("index_out %0h, want %0h", rsp_if.index_out, want.index_out));
        if (rsp_if.price_out !== want.price_out)
          flag_mismatch($sformatf("price_out %0h, want %0h", rsp_if.price_out, want.price_out));
        if (rsp_if.status !== want.status)
          flag_mismatch($sformatf("status %0h, want %0h", rsp_if.status, want.status));
      end
    end
  end

  task automatic queue_item(plu_pkg::opcode_t op, int idx,
                            logic [plu_pkg::PRICE_IO_W-1:0] px, bit s);
    ladder_req_t it;
    it.op     = op;
    it.index  = idx[plu_pkg::IDX_IN_W-1:0];
    it.price  = px;
    it.strict = s;
    pending_q.insert(pending_q.size(), it);
    if (op == plu_pkg::OP_WRITE && idx >= 0 && idx < LADDER_DEPTH) plan_ladder[idx] = px;
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || sent_cnt != accepted_cnt || answer_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_entry_count(int v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[plu_pkg::CNT_W-1:0];
    @(posedge clk);
    entry_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // descending ladder, or now and then a scrambled one
  task automatic build_ladder(int n);
    logic [plu_pkg::PRICE_IO_W-1:0] v;
    int                             k;
    bit                             noisy;
    noisy = ($urandom_range(0, 7) == 0);
    v     = 32'hF000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
    k     = (n <= 64) ? $urandom_range(0, 25) : $urandom_range(0, 21);
    for (int i = 0; i < n; i++) begin
      queue_item(plu_pkg::OP_WRITE, i, noisy ? $urandom : v, $urandom_range(0, 1));
      v = v - $urandom_range(1, 1 << k);
    end
    if (n > written_prefix) written_prefix = n;
  endtask

  function automatic int pick_index(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return int'($urandom_range(0, 4095)) - 2048;
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0:       return -2048;
        1:       return 2047;
        2:       return -1;
        default: return n;
      endcase
    end
    return int'($urandom_range(0, n + 1)) - 1;
  endfunction

  task automatic random_item(int n);
    int                             r;
    int                             i;
    logic [plu_pkg::PRICE_IO_W-1:0] px;
    bit                             s;
    s = $urandom_range(0, 1);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 2))
        0: i = (n > 0) ? $urandom_range(0, n - 1) : 0;
        1: i = $urandom_range(0, 1) ? -int'($urandom_range(1, 2048))
                                    : int'($urandom_range(LADDER_DEPTH, 2047));
        default: i = $urandom_range(0, LADDER_DEPTH - 1);
      endcase
      queue_item(plu_pkg::OP_WRITE, i, $urandom, s);
    end else if (r < 55) begin
      i = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: px = plan_ladder[i];
        5:             px = plan_ladder[i] + 1;
        6:             px = plan_ladder[i] - 1;
        7:             px = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default:       px = $urandom;
      endcase
      queue_item(plu_pkg::OP_TO_INDEX, pick_index(n), px, s);
    end else if (r < 80) begin
      queue_item(plu_pkg::OP_TO_PRICE, pick_index(n), $urandom, s);
    end else begin
      queue_item(plu_pkg::OP_TICK, pick_index(n), $urandom, s);
    end
  endtask

  initial begin
    int phase;
    int cnt;
    int used;
    int r;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_if.valid     = 1'b0;
    req_if.opcode    = '0;
    req_if.index_in  = '0;
    req_if.price_in  = '0;
    req_if.strict    = 1'b0;
    rsp_if.ready     = 1'b0;
    sent_cnt         = 0;
    accepted_cnt     = 0;
    queued_cnt       = 0;
    mismatch_cnt     = 0;
    cycle_cnt        = 0;
    entry_cfg        = 0;
    written_prefix   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty ladder, writes outside and inside the ladder
    set_entry_count(0);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'd5, 1'b0);
    queue_item(plu_pkg::OP_TO_PRICE, 0, 32'd0, 1'b1);
    queue_item(plu_pkg::OP_TICK, 0, 32'd0, 1'b0);
    queue_item(plu_pkg::OP_WRITE, -2048, 32'hFFFF_FFFF, 1'b1);
    queue_item(plu_pkg::OP_WRITE, 2047, 32'd0, 1'b1);
    queue_item(plu_pkg::OP_WRITE, LADDER_DEPTH, 32'd7, 1'b0);
    queue_item(plu_pkg::OP_WRITE, -1, 32'd7, 1'b0);
    queue_item(plu_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, 1'b1);
    queue_item(plu_pkg::OP_WRITE, 1, 32'd1000, 1'b0);
    queue_item(plu_pkg::OP_WRITE, 2, 32'd500, 1'b1);
    queue_item(plu_pkg::OP_WRITE, 3, 32'd0, 1'b0);
    written_prefix = 4;

    // single entry: tick step too short, lookups on the one entry
    set_entry_count(1);
    queue_item(plu_pkg::OP_TICK, 1, 32'd0, 1'b1);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'd0, 1'b0);
    queue_item(plu_pkg::OP_TO_PRICE, -5, 32'd0, 1'b1);

    // hits, strict misses, clamps
    set_entry_count(4);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'hFFFF_FFFF, 1'b0);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'd1000, 1'b1);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'd700, 1'b1);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'd700, 1'b0);
    queue_item(plu_pkg::OP_TO_INDEX, 0, 32'd0, 1'b0);
    queue_item(plu_pkg::OP_TO_PRICE, 2047, 32'd0, 1'b1);
    queue_item(plu_pkg::OP_TO_PRICE, 2047, 32'd0, 1'b0);
    queue_item(plu_pkg::OP_TO_PRICE, -2048, 32'd0, 1'b0);
    queue_item(plu_pkg::OP_TICK, -2048, 32'd0, 1'b0);
    queue_item(plu_pkg::OP_TICK, 2047, 32'd0, 1'b1);
    queue_item(plu_pkg::OP_TICK, 1, 32'd0, 1'b0);

    phase = 0;
    while (queued_cnt < 1925) begin
      if (phase == 3) begin
        cnt = 2047;
      end else if (phase == 9) begin
        cnt = LADDER_DEPTH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) cnt = 0;
        else if (r < 12) cnt = 1;
        else if (r < 18) cnt = 2;
        else if (r < 30 && written_prefix >= LADDER_DEPTH) cnt = $urandom_range(65, 1023);
        else cnt = $urandom_range(3, 48);
      end
      used = (cnt > LADDER_DEPTH) ? LADDER_DEPTH : cnt;
      set_entry_count(cnt);
      if (used > 0 && (written_prefix < used || used <= 64)) build_ladder(used);
      repeat (70) random_item(used);
      phase++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS price_ladder_lookup_unit");
    end else begin
      $display("FAIL price_ladder_lookup_unit");
    end
    $finish;
  end

endmodule
